// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be seen at a rising edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/dttm_pkg.sv =====
// ----------------------------------------------------------------------------
// dttm_pkg
// Types, codes and helpers for the delimited tag trie matcher.
// ----------------------------------------------------------------------------
package dttm_pkg;

	localparam int ALPHABET_SIZE = 64;
	localparam int CODE_BITS     = 6;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QUEUE_AW      = 1;

	// configuration register indexes
	localparam logic [1:0] CFG_DELIMITER     = 2'd0;
	localparam logic [1:0] CFG_PRINT_TEXT    = 2'd1;
	localparam logic [1:0] CFG_REPORT_ERRORS = 2'd2;

	localparam logic [7:0] DELIMITER_RST = 8'd36;

	typedef enum logic [1:0] {
		OP_SCAN   = 2'd0,
		OP_ADD    = 2'd1,
		OP_FINISH = 2'd2,
		OP_END    = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		KIND_TEXT    = 3'd0,
		KIND_MATCH   = 3'd1,
		KIND_UNKNOWN = 3'd2,
		KIND_EOS     = 3'd3,
		KIND_REJECT  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_ISSUE,
		ST_RESOLVE
	} state_t;

	typedef struct packed {
		logic [7:0] delimiter;
		logic       print_text;
		logic       report_errors;
	} cfg_t;

	typedef struct packed {
		opcode_t                opcode;
		logic [7:0]             ch;
		logic [15:0]            id;
		logic                   is_delim;
		logic                   sym_ok;
		logic [CODE_BITS-1:0]   code;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic [15:0] id;
		logic        err;
	} result_t;

	// {in alphabet, symbol code}; slot 26 is never produced
	function automatic logic [CODE_BITS:0] sym_code(input logic [7:0] c);
		logic [CODE_BITS:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, CODE_BITS'(c - 8'd48)};
		else if (c >= 8'h41 && c <= 8'h50)
			r = {1'b1, CODE_BITS'(c - 8'd55)};
		else if (c >= 8'h51 && c <= 8'h5a)
			r = {1'b1, CODE_BITS'(c - 8'd54)};
		else if (c == 8'h5f)
			r = {1'b1, CODE_BITS'(37)};
		else if (c >= 8'h61 && c <= 8'h7a)
			r = {1'b1, CODE_BITS'(c - 8'd59)};
		return r;
	endfunction

endpackage

// ===== rtl/core/delimited_tag_trie_matcher.sv =====
// Flow: the issue state pops a queued item and reads the link and id RAMs; the resolve
// state registers any result, waiting while m_axis holds an earlier one. Items are walked
// one at a time, as the trie link RAM read data picks the next node before the following
// item can address the RAM. Reset: asynchronous, active low; a clearing pass then zeroes
// the link and id memories with s_axis_tready low; cfg writes are taken throughout.
// ----------------------------------------------------------------------------
// delimited_tag_trie_matcher
// Trie tag loader and delimited tag scanner, stream in and stream out.
// ----------------------------------------------------------------------------
module delimited_tag_trie_matcher #(
	parameter int MAX_NODES = 256,
	parameter int ID_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // char_in[7:0], tag_id_in[23:8]
	input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // out_char[7:0], tag_id[23:8], error_flag[24], zero
	output logic [2:0]  m_axis_tuser   // kind[2:0]
);

	dttm_pkg::cfg_t    cfg_q;
	dttm_pkg::item_t   push_item, head_item;
	dttm_pkg::result_t result;
	logic              q_push, q_pop, q_full, q_empty, back_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter     <= dttm_pkg::DELIMITER_RST;
			cfg_q.print_text    <= 1'b1;
			cfg_q.report_errors <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dttm_pkg::CFG_DELIMITER:     cfg_q.delimiter     <= cfg_data;
				dttm_pkg::CFG_PRINT_TEXT:    cfg_q.print_text    <= cfg_data[0];
				dttm_pkg::CFG_REPORT_ERRORS: cfg_q.report_errors <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dttm_front u_front (
		.cfg        (cfg_q),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tuser    (s_axis_tuser),
		.back_ready (back_ready),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	dttm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (push_item),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head    (head_item)
	);

	dttm_back #(.MAX_NODES(MAX_NODES), .ID_BITS(ID_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_head   (head_item),
		.q_pop    (q_pop),
		.ready    (back_ready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_result (result)
	);

	assign m_axis_tdata = {7'd0, result.err, result.id, result.ch};
	assign m_axis_tuser = result.kind;

endmodule

// ===== rtl/core/dttm_ram.sv =====
// ----------------------------------------------------------------------------
// dttm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dttm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/dttm_front.sv =====
// ----------------------------------------------------------------------------
// dttm_front
// Input handshake and item classification (delimiter, alphabet code).
// ----------------------------------------------------------------------------
module dttm_front (
	input  dttm_pkg::cfg_t  cfg,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [23:0]     s_tdata,
	input  logic [1:0]      s_tuser,
	input  logic            back_ready,
	input  logic            q_full,
	output logic            q_push,
	output dttm_pkg::item_t q_item
);

	logic [dttm_pkg::CODE_BITS:0] sym;

	assign sym      = dttm_pkg::sym_code(s_tdata[7:0]);
	assign s_tready = back_ready && !q_full;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		q_item.opcode   = dttm_pkg::opcode_t'(s_tuser);
		q_item.ch       = s_tdata[7:0];
		q_item.id       = s_tdata[23:8];
		q_item.is_delim = (s_tdata[7:0] == cfg.delimiter);
		q_item.sym_ok   = sym[dttm_pkg::CODE_BITS];
		q_item.code     = sym[dttm_pkg::CODE_BITS-1:0];
	end

endmodule

// ===== rtl/core/dttm_queue.sv =====
// ----------------------------------------------------------------------------
// dttm_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module dttm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dttm_pkg::item_t wr_item,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output dttm_pkg::item_t head
);

	dttm_pkg::item_t                 slot_q [dttm_pkg::QUEUE_DEPTH];
	logic [dttm_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [dttm_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [dttm_pkg::QUEUE_AW:0]     count_q;

	assign full  = (count_q == (dttm_pkg::QUEUE_AW+1)'(dttm_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/dttm_back.sv =====
// ----------------------------------------------------------------------------
// dttm_back
// Trie walker: link and id memories, scan/load walks, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dttm_back #(
	parameter int MAX_NODES = 256,
	parameter int ID_BITS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dttm_pkg::cfg_t    cfg,
	input  logic              q_empty,
	input  dttm_pkg::item_t   q_head,
	output logic              q_pop,
	output logic              ready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output dttm_pkg::result_t m_result
);

	localparam int NODE_AW    = $clog2(MAX_NODES);
	localparam int LINK_AW    = NODE_AW + dttm_pkg::CODE_BITS;
	localparam int LINK_DEPTH = MAX_NODES * dttm_pkg::ALPHABET_SIZE;
	localparam logic [NODE_AW:0] FREE_MAX = (NODE_AW+1)'(MAX_NODES);

	dttm_pkg::state_t  state_q, state_nx;
	logic [LINK_AW-1:0] clr_q;
	logic               in_tag_q;
	logic [NODE_AW-1:0] scan_node_q;
	logic [NODE_AW-1:0] load_node_q;
	logic [NODE_AW:0]   free_q;
	dttm_pkg::item_t    cur_q;
	logic               out_valid_q;
	dttm_pkg::result_t  out_q;

	logic               link_we, link_re;
	logic [LINK_AW-1:0] link_waddr, link_raddr;
	logic [NODE_AW-1:0] link_wdata, link_rdata;
	logic [NODE_AW:0]   link_ext;
	logic               id_we, id_re;
	logic [NODE_AW-1:0] id_waddr, id_raddr;
	logic [ID_BITS:0]   id_wdata, id_rdata;

	dttm_pkg::result_t  res;
	logic               res_valid, hold, commit, alloc;
	logic               nx_in_tag;
	logic [NODE_AW-1:0] nx_scan, nx_load;

	dttm_ram #(.WIDTH(NODE_AW), .DEPTH(LINK_DEPTH)) u_links (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	dttm_ram #(.WIDTH(ID_BITS+1), .DEPTH(MAX_NODES)) u_ids (
		.clk   (clk),
		.we    (id_we),
		.waddr (id_waddr),
		.wdata (id_wdata),
		.re    (id_re),
		.raddr (id_raddr),
		.rdata (id_rdata)
	);

	assign link_ext = {1'b0, link_rdata};
	assign hold     = res_valid && out_valid_q && !m_tready;
	assign commit   = (state_q == dttm_pkg::ST_RESOLVE) && !hold;
	assign ready    = (state_q != dttm_pkg::ST_CLEAR);
	assign m_tvalid = out_valid_q;
	assign m_result = out_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dttm_pkg::ST_CLEAR:   if (clr_q == LINK_AW'(LINK_DEPTH - 1)) state_nx = dttm_pkg::ST_ISSUE;
			dttm_pkg::ST_ISSUE:   if (!q_empty) state_nx = dttm_pkg::ST_RESOLVE;
			dttm_pkg::ST_RESOLVE: if (!hold) state_nx = dttm_pkg::ST_ISSUE;
			default:              state_nx = dttm_pkg::ST_CLEAR;
		endcase
	end

	// memory and queue controls
	always_comb begin
		q_pop      = 1'b0;
		link_re    = 1'b0;
		id_re      = 1'b0;
		link_we    = 1'b0;
		id_we      = 1'b0;
		link_raddr = {(cur_q.opcode == dttm_pkg::OP_ADD) ? load_node_q : scan_node_q,
			cur_q.code};
		id_raddr   = scan_node_q;
		link_waddr = {load_node_q, cur_q.code};
		link_wdata = free_q[NODE_AW-1:0];
		id_waddr   = load_node_q;
		id_wdata   = {1'b1, ID_BITS'(cur_q.id)};
		unique case (state_q)
			dttm_pkg::ST_CLEAR: begin
				link_we    = 1'b1;
				id_we      = 1'b1;
				link_waddr = clr_q;
				link_wdata = '0;
				id_waddr   = clr_q[NODE_AW-1:0];
				id_wdata   = '0;
			end
			dttm_pkg::ST_ISSUE: begin
				q_pop      = !q_empty;
				link_re    = !q_empty;
				id_re      = !q_empty;
				link_raddr = {(q_head.opcode == dttm_pkg::OP_ADD) ? load_node_q : scan_node_q,
					q_head.code};
			end
			dttm_pkg::ST_RESOLVE: begin
				link_we = commit && alloc;
				id_we   = commit && (cur_q.opcode == dttm_pkg::OP_FINISH);
			end
			default: ;
		endcase
	end

	// item execution
	always_comb begin
		res       = '{kind: dttm_pkg::KIND_TEXT, ch: '0, id: '0, err: 1'b0};
		res_valid = 1'b0;
		alloc     = 1'b0;
		nx_in_tag = in_tag_q;
		nx_scan   = scan_node_q;
		nx_load   = load_node_q;
		unique case (cur_q.opcode)
			dttm_pkg::OP_SCAN: begin
				if (!in_tag_q) begin
					if (cur_q.is_delim) begin
						nx_in_tag = 1'b1;
						nx_scan   = '0;
					end else if (cfg.print_text) begin
						res_valid = 1'b1;
						res.ch    = cur_q.ch;
					end
				end else if (cur_q.is_delim) begin
					nx_in_tag = 1'b0;
					nx_scan   = '0;
					res_valid = 1'b1;
					if (id_rdata[ID_BITS]) begin
						res.kind = dttm_pkg::KIND_MATCH;
						res.id   = 16'(id_rdata[ID_BITS-1:0]);
					end else begin
						res.kind = dttm_pkg::KIND_UNKNOWN;
						res.err  = cfg.report_errors;
					end
				end else if (!cur_q.sym_ok || link_rdata == '0) begin
					nx_in_tag = 1'b0;
					nx_scan   = '0;
					res_valid = 1'b1;
					res.kind  = dttm_pkg::KIND_UNKNOWN;
					res.err   = cfg.report_errors;
				end else begin
					nx_scan = link_rdata;
				end
			end
			dttm_pkg::OP_ADD: begin
				if (!cur_q.sym_ok) begin
					res_valid = 1'b1;
					res.kind  = dttm_pkg::KIND_REJECT;
				end else if (link_rdata != '0) begin
					nx_load = link_rdata;
				end else if (free_q >= FREE_MAX) begin
					res_valid = 1'b1;
					res.kind  = dttm_pkg::KIND_REJECT;
				end else begin
					alloc   = 1'b1;
					nx_load = free_q[NODE_AW-1:0];
				end
			end
			dttm_pkg::OP_FINISH: begin
				nx_load = '0;
			end
			dttm_pkg::OP_END: begin
				res_valid = 1'b1;
				if (in_tag_q) begin
					nx_in_tag = 1'b0;
					nx_scan   = '0;
					res.kind  = dttm_pkg::KIND_UNKNOWN;
					res.err   = cfg.report_errors;
				end else begin
					res.kind = dttm_pkg::KIND_EOS;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_head;
		if (commit && res_valid)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dttm_pkg::ST_CLEAR;
			clr_q       <= '0;
			in_tag_q    <= 1'b0;
			scan_node_q <= '0;
			load_node_q <= '0;
			free_q      <= {{NODE_AW{1'b0}}, 1'b1};
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == dttm_pkg::ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (commit) begin
				in_tag_q    <= nx_in_tag;
				scan_node_q <= nx_scan;
				load_node_q <= nx_load;
				if (alloc)
					free_q <= free_q + 1'b1;
			end
			if (commit && res_valid)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	`ASSERT_NEVER(a_free_bound, clk, arst_n, free_q > FREE_MAX, "node pool count overrun")
	`ASSERT_CLK(a_text_root, clk, arst_n,
		!in_tag_q |-> (scan_node_q == '0), "scan walk off root in text mode")
	`ASSERT_CLK(a_link_bound, clk, arst_n,
		(state_q == dttm_pkg::ST_RESOLVE) |-> (link_ext < free_q), "link to unallocated node")

endmodule

// ===== bench/delimited_tag_trie_matcher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delimited_tag_trie_matcher_tb
// Loads tags into the trie and scans delimited text through the stream ports
// under several register settings, with random gaps on both sides. A trie
// model inside the bench predicts every result item and checks it field by
// field.
// ----------------------------------------------------------------------------
module delimited_tag_trie_matcher_tb;

	localparam int NODES       = 256;
	localparam int QUIET_LIMIT = 50000;
	localparam int TAG_SLOTS   = 64;
	localparam int TAG_MAX     = 8;
	localparam int POOL_SCAN   = 12;
	localparam logic [7:0]  DOLLAR      = 8'h24;
	localparam logic [47:0] COMMON_SYMS = {8'h61, 8'h62, 8'h41, 8'h5A, 8'h5F, 8'h30};

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_index     = dttm_pkg::CFG_DELIMITER;
	logic [7:0]  cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;  // char_in[7:0], tag_id_in[23:8]
	logic [1:0]  s_axis_tuser  = dttm_pkg::OP_SCAN;  // opcode[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;  // out_char[7:0], tag_id[23:8], error_flag[24], zero
	logic [2:0]  m_axis_tuser;  // kind[2:0]

	// trie model
	dttm_pkg::cfg_t    regs;
	logic [7:0]        trie_child [NODES][dttm_pkg::ALPHABET_SIZE];
	logic              node_tagged [NODES];
	logic [15:0]       node_tag_id [NODES];
	int                nodes_used;
	logic              in_tag;
	logic [7:0]        scan_pos;
	logic [7:0]        load_pos;
	dttm_pkg::result_t pending_results [$];

	// tags known to have been loaded
	logic [7:0]  tag_text [TAG_SLOTS][TAG_MAX];
	int          tag_len [TAG_SLOTS];
	int          tag_count;

	int items_sent;
	int results_seen;
	int errors;
	int kind_seen [8];
	int quiet_cycles;
	int rx_hold;
	bit tx_idle;
	bit rx_idle;

	delimited_tag_trie_matcher #(
		.MAX_NODES(NODES),
		.ID_BITS  (16)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// alphabet slot of a byte, -1 outside; slot 26 is skipped
	function automatic int alpha_slot(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
		if (c >= 8'h41 && c <= 8'h50) return c - 8'h41 + 10;
		if (c >= 8'h51 && c <= 8'h5A) return c - 8'h51 + 27;
		if (c == 8'h5F) return 37;
		if (c >= 8'h61 && c <= 8'h7A) return c - 8'h61 + 38;
		return -1;
	endfunction

	function automatic void clear_model();
		regs.delimiter     = dttm_pkg::DELIMITER_RST;
		regs.print_text    = 1'b1;
		regs.report_errors = 1'b1;
		for (int n = 0; n < NODES; n++) begin
			node_tagged[n] = 1'b0;
			node_tag_id[n] = '0;
			for (int s = 0; s < dttm_pkg::ALPHABET_SIZE; s++)
				trie_child[n][s] = '0;
		end
		nodes_used = 1;
		in_tag     = 1'b0;
		scan_pos   = '0;
		load_pos   = '0;
	endfunction

	function automatic void expect_result(dttm_pkg::kind_t k, logic [7:0] c, logic [15:0] id,
		logic e);
		dttm_pkg::result_t r;
		r.kind = k;
		r.ch   = c;
		r.id   = id;
		r.err  = e;
		pending_results.push_back(r);
	endfunction

	function automatic void drop_tag();
		in_tag   = 1'b0;
		scan_pos = '0;
		expect_result(dttm_pkg::KIND_UNKNOWN, 8'd0, 16'd0, regs.report_errors);
	endfunction

	function automatic void step_matcher(dttm_pkg::opcode_t op, logic [7:0] c, logic [15:0] id);
		int slot;
		slot = alpha_slot(c);
		case (op)
		dttm_pkg::OP_SCAN: begin
			if (!in_tag) begin
				if (c == regs.delimiter) begin
					in_tag   = 1'b1;
					scan_pos = '0;
				end else if (regs.print_text) begin
					expect_result(dttm_pkg::KIND_TEXT, c, 16'd0, 1'b0);
				end
			end else if (c == regs.delimiter) begin
				if (node_tagged[scan_pos]) begin
					expect_result(dttm_pkg::KIND_MATCH, 8'd0, node_tag_id[scan_pos], 1'b0);
					in_tag   = 1'b0;
					scan_pos = '0;
				end else begin
					drop_tag();
				end
			end else if (slot < 0 || trie_child[scan_pos][slot] == '0) begin
				drop_tag();
			end else begin
				scan_pos = trie_child[scan_pos][slot];
			end
		end
		dttm_pkg::OP_ADD: begin
			if (slot < 0 || (trie_child[load_pos][slot] == '0 && nodes_used >= NODES)) begin
				expect_result(dttm_pkg::KIND_REJECT, 8'd0, 16'd0, 1'b0);
			end else begin
				if (trie_child[load_pos][slot] == '0) begin
					trie_child[load_pos][slot] = 8'(nodes_used);
					nodes_used++;
				end
				load_pos = trie_child[load_pos][slot];
			end
		end
		dttm_pkg::OP_FINISH: begin
			node_tagged[load_pos] = 1'b1;
			node_tag_id[load_pos] = id;
			load_pos = '0;
		end
		default: begin
			if (in_tag)
				drop_tag();
			else
				expect_result(dttm_pkg::KIND_EOS, 8'd0, 16'd0, 1'b0);
		end
		endcase
	endfunction

	function automatic logic [7:0] pick_symbol();
		logic [7:0] c;
		if ($urandom_range(0, 3) != 0) begin
			c = COMMON_SYMS[8 * $urandom_range(0, 5) +: 8];
		end else begin
			c = 8'($urandom);
			while (alpha_slot(c) < 0) c = 8'($urandom);
		end
		return c;
	endfunction

	function automatic logic [7:0] pick_foreign();
		logic [7:0] c;
		c = 8'($urandom);
		while (alpha_slot(c) >= 0) c = 8'($urandom);
		return c;
	endfunction

	task automatic send_item(dttm_pkg::opcode_t op, logic [7:0] c, logic [15:0] id);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {id, c};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		step_matcher(op, c, id);
	endtask

	task automatic scan_byte(logic [7:0] c);
		send_item(dttm_pkg::OP_SCAN, c, 16'($urandom));
	endtask

	task automatic add_byte(logic [7:0] c);
		send_item(dttm_pkg::OP_ADD, c, 16'($urandom));
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(logic [7:0] delim, logic pt, logic re);
		cfg_we    <= 1'b1;
		cfg_index <= dttm_pkg::CFG_DELIMITER;
		cfg_data  <= delim;
		@(posedge clk);
		cfg_index <= dttm_pkg::CFG_PRINT_TEXT;
		cfg_data  <= {7'd0, pt};
		@(posedge clk);
		cfg_index <= dttm_pkg::CFG_REPORT_ERRORS;
		cfg_data  <= {7'd0, re};
		@(posedge clk);
		cfg_we <= 1'b0;
		regs.delimiter     = delim;
		regs.print_text    = pt;
		regs.report_errors = re;
	endtask

	task automatic load_random_tag();
		int k;
		int len;
		logic [7:0] c;
		if (tag_count < TAG_SLOTS) begin
			k = tag_count;
			tag_count++;
		end else begin
			k = $urandom_range(0, TAG_SLOTS - 1);
		end
		len = $urandom_range(0, 5);
		for (int j = 0; j < len; j++) begin
			if ($urandom_range(0, 7) == 0) add_byte(pick_foreign());
			c = pick_symbol();
			add_byte(c);
			tag_text[k][j] = c;
		end
		tag_len[k] = len;
		send_item(dttm_pkg::OP_FINISH, 8'($urandom), 16'($urandom));
	endtask

	// optionally loads a one-byte tag partway through the walk
	task automatic scan_known_tag(int k, bit interleave);
		scan_byte(regs.delimiter);
		for (int j = 0; j < tag_len[k]; j++) begin
			scan_byte(tag_text[k][j]);
			if (interleave && j == 0) begin
				add_byte(pick_symbol());
				send_item(dttm_pkg::OP_FINISH, 8'($urandom), 16'($urandom));
			end
		end
		scan_byte(regs.delimiter);
	endtask

	task automatic test_special_cases();
		send_item(dttm_pkg::OP_END, 8'h00, 16'h0000);
		scan_byte(8'hFF);
		// empty tag on the root, matched by two adjacent delimiters
		send_item(dttm_pkg::OP_FINISH, 8'hFF, 16'hFFFF);
		scan_byte(DOLLAR);
		scan_byte(DOLLAR);
		add_byte(8'h61);
		add_byte(8'h62);
		send_item(dttm_pkg::OP_FINISH, 8'h00, 16'h0000);
		// same tag again with bytes outside the alphabet mixed in; newer id wins
		add_byte(8'h61);
		add_byte(8'h00);
		add_byte(8'h62);
		add_byte(8'hFF);
		send_item(dttm_pkg::OP_FINISH, 8'h00, 16'hA55A);
		// loading during a scan
		scan_byte(DOLLAR);
		scan_byte(8'h61);
		add_byte(8'h5A);
		scan_byte(8'h62);
		scan_byte(DOLLAR);
		send_item(dttm_pkg::OP_FINISH, 8'h00, 16'h7FFF);
		// node without id
		scan_byte(DOLLAR);
		scan_byte(8'h61);
		scan_byte(DOLLAR);
		// missing branch, the rest goes out as text
		scan_byte(DOLLAR);
		scan_byte(8'h78);
		scan_byte(8'h79);
		// byte outside the alphabet inside a tag
		scan_byte(DOLLAR);
		scan_byte(8'h00);
		// end of input inside a tag
		scan_byte(DOLLAR);
		send_item(dttm_pkg::OP_END, 8'hFF, 16'hFFFF);
	endtask

	task automatic test_register_extremes();
		wait_idle();
		// delimiter inside the alphabet, text dropped, errors quiet
		write_regs(8'h61, 1'b0, 1'b0);
		scan_byte(8'h30);
		scan_byte(8'h61);
		scan_byte(8'h5A);
		scan_byte(8'h61);
		scan_byte(8'h61);
		scan_byte(8'h78);
		send_item(dttm_pkg::OP_END, 8'h00, 16'h0000);
		wait_idle();
		write_regs(8'h00, 1'b1, 1'b1);
		scan_byte(8'h00);
		scan_byte(8'h61);
		scan_byte(8'h62);
		scan_byte(8'h00);
		scan_byte(DOLLAR);
		wait_idle();
		write_regs(8'hFF, 1'b1, 1'b0);
		scan_byte(8'hFF);
		scan_byte(8'h61);
		scan_byte(8'hFF);
		scan_byte(8'hFF);
		scan_byte(8'hFF);
	endtask

	task automatic test_random_traffic(int n_items, bit idle);
		int target;
		int n;
		logic [7:0] delim;
		wait_idle();
		case ($urandom_range(0, 4))
		0:       delim = DOLLAR;
		1:       delim = 8'h00;
		2:       delim = 8'hFF;
		3:       delim = pick_symbol();
		default: delim = 8'($urandom);
		endcase
		write_regs(delim, 1'($urandom_range(0, 3) != 0), 1'($urandom));
		tx_idle = idle;
		rx_idle = idle;
		target = items_sent + n_items;
		while (items_sent < target) begin
			case ($urandom_range(0, 9))
			0, 1, 2: begin
				load_random_tag();
			end
			3, 4, 5: begin
				if (tag_count != 0)
					scan_known_tag($urandom_range(0, tag_count - 1), 1'b0);
				else
					scan_byte(8'($urandom));
			end
			6: begin
				repeat ($urandom_range(1, 6)) scan_byte(8'($urandom));
			end
			7: begin
				// random tag walk, ended by end of input, a foreign byte or the delimiter
				scan_byte(regs.delimiter);
				n = $urandom_range(0, 3);
				repeat (n) scan_byte(pick_symbol());
				case ($urandom_range(0, 2))
				0:       send_item(dttm_pkg::OP_END, 8'($urandom), 16'($urandom));
				1:       scan_byte(pick_foreign());
				default: scan_byte(regs.delimiter);
				endcase
			end
			8: begin
				send_item(dttm_pkg::OP_END, 8'($urandom), 16'($urandom));
			end
			default: begin
				if (tag_count != 0)
					scan_known_tag($urandom_range(0, tag_count - 1), 1'b1);
			end
			endcase
		end
	endtask

	task automatic test_node_pool_limit();
		logic [7:0] chain [$];
		logic [7:0] c;
		int slot;
		int extra;
		int guard;
		bit full;
		wait_idle();
		write_regs(DOLLAR, 1'b1, 1'b1);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		extra = 0;
		guard = 0;
		// one long tag until the pool runs dry, then a couple of refused bytes
		while (extra < 2 && guard < 600) begin
			c = pick_symbol();
			slot = alpha_slot(c);
			full = nodes_used >= NODES;
			if (trie_child[load_pos][slot] != '0 || !full) chain.push_back(c);
			add_byte(c);
			if (full) extra++;
			guard++;
		end
		send_item(dttm_pkg::OP_FINISH, 8'($urandom), 16'($urandom));
		// walk the first bytes of the long tag
		scan_byte(DOLLAR);
		foreach (chain[j])
			if (j < POOL_SCAN) scan_byte(chain[j]);
		scan_byte(DOLLAR);
	endtask

	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else if (rx_idle && $urandom_range(0, 7) == 0) begin
			rx_hold = $urandom_range(0, 14);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		dttm_pkg::result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected: kind %0d", m_axis_tuser);
				errors++;
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				kind_seen[want.kind]++;
				if (m_axis_tuser !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[7:0] !== want.ch) begin
					$error("out_char: expected %0h, got %0h", want.ch, m_axis_tdata[7:0]);
					errors++;
				end
				if (m_axis_tdata[23:8] !== want.id) begin
					$error("tag_id: expected %0h, got %0h", want.id, m_axis_tdata[23:8]);
					errors++;
				end
				if (m_axis_tdata[24] !== want.err) begin
					$error("error_flag: expected %0b, got %0b", want.err, m_axis_tdata[24]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no item moved for %0d cycles, %0d results outstanding", quiet_cycles,
				pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		clear_model();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_register_extremes();
		for (int p = 0; p < 5; p++) test_random_traffic(35, p != 2);
		test_node_pool_limit();
		test_random_traffic(60, 1'b0);
		wait_idle();
		$display("Run sent %0d items and checked %0d results: %0d text, %0d matched, %0d unknown,",
			items_sent, results_seen, kind_seen[dttm_pkg::KIND_TEXT],
			kind_seen[dttm_pkg::KIND_MATCH], kind_seen[dttm_pkg::KIND_UNKNOWN]);
		$display("%0d end of stream, %0d refused adds; trie filled to %0d of %0d nodes.",
			kind_seen[dttm_pkg::KIND_EOS], kind_seen[dttm_pkg::KIND_REJECT], nodes_used, NODES);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
